// ===== src/rbpa_pkg.sv =====
// Shared constants, state encoding and control structs for the block pool allocator.
// No dependencies; imported by the controller, datapath, top level and testbench.
`default_nettype none
package rbpa_pkg;
   localparam int NUM_REGIONS   = 8;
   localparam int REGION_BLOCKS = 255;
   localparam int REG_W   = 3;               // region index
   localparam int PTR_W   = REG_W + 1;       // region pointer with empty marker
   localparam int BLK_W   = 8;               // block index
   localparam int FILL_W  = BLK_W + 1;       // lazy fill mark, up to 256
   localparam int STEP_W  = REG_W + 1;       // list walk step count
   localparam int ADDR_W  = REG_W + BLK_W;   // link memory address
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam logic [PTR_W-1:0] NO_REGION = PTR_W'(NUM_REGIONS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREE_CHK,
      ST_FILL,
      ST_PUSH,
      ST_SCAN,
      ST_POP_RD,
      ST_POP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;       // latch request, start list walk at head
      logic scan_step;  // follow next pointer
      logic take;       // current region has a free block
      logic activate;   // bring up lowest inactive region
      logic set_fail;   // allocate failed
      logic set_zero;   // ignored free
      logic pop_rd;     // read link of region head block
      logic pop;        // unlink head block
      logic fill_step;  // write one lazily filled link
      logic push;       // push freed block
      logic rsp_load;   // move pending result to output register
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic cur_end;
      logic cur_hit;
      logic can_activate;
      logic free_ok;
      logic need_fill;
      logic fill_last;
   } sts_type;
endpackage
`default_nettype wire

// ===== src/rbpa_ctrl.sv =====
// Controller state machine for the block pool allocator.
// Depends on rbpa_pkg; drives commands to rbpa_dp and the output handshake.
`default_nettype none
module rbpa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire rbpa_pkg::sts_type sts,
   output rbpa_pkg::cmd_type      cmd
);
   import rbpa_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = sts.is_free ? ST_FREE_CHK : ST_SCAN;
         end
         ST_FREE_CHK: begin
            if (!sts.free_ok)       state_in = ST_DONE;
            else if (sts.need_fill) state_in = ST_FILL;
            else                    state_in = ST_PUSH;
         end
         ST_FILL: begin
            if (sts.fill_last) state_in = ST_DONE;
         end
         ST_PUSH: state_in = ST_DONE;
         ST_SCAN: begin
            if (sts.cur_end)      state_in = sts.can_activate ? ST_POP_RD : ST_DONE;
            else if (sts.cur_hit) state_in = ST_POP_RD;
         end
         ST_POP_RD: state_in = ST_POP;
         ST_POP:    state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:     cmd.load = accept;
         ST_FREE_CHK: cmd.set_zero = !sts.free_ok;
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            cmd.push      = sts.fill_last;
         end
         ST_PUSH: cmd.push = 1'b1;
         ST_SCAN: begin
            if (sts.cur_end) begin
               cmd.activate = sts.can_activate;
               cmd.set_fail = !sts.can_activate;
            end else if (sts.cur_hit) begin
               cmd.take = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_POP_RD: cmd.pop_rd = 1'b1;
         ST_POP:    cmd.pop = 1'b1;
         ST_DONE:   cmd.rsp_load = slot_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)     rsp_valid_in = 1'b1;
      else if (rsp_tready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/rbpa_dp.sv =====
// Datapath: region table, region list, link memory with lazy fill, result registers.
// Depends on rbpa_pkg; steered by commands from rbpa_ctrl.
`default_nettype none
module rbpa_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [15:0]       req_tdata,
   input  wire logic              req_tuser,
   output logic [15:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser,
   input  wire rbpa_pkg::cmd_type cmd,
   output rbpa_pkg::sts_type      sts
);
   import rbpa_pkg::*;

   // region table
   logic              active_ff [NUM_REGIONS];
   logic [BLK_W-1:0]  cnt_ff    [NUM_REGIONS];
   logic [BLK_W-1:0]  head_ff   [NUM_REGIONS];
   logic [FILL_W-1:0] fill_ff   [NUM_REGIONS];   // links at or above are implicit b+1
   logic [PTR_W-1:0]  next_ff   [NUM_REGIONS];
   logic [PTR_W-1:0]  prev_ff   [NUM_REGIONS];
   logic [PTR_W-1:0]  list_head_ff;

   // request and walk
   logic              mode_ff;
   logic [REG_W-1:0]  rr_ff;
   logic [BLK_W-1:0]  bb_ff;
   logic [PTR_W-1:0]  cur_ff;
   logic [STEP_W-1:0] steps_ff;
   logic [REG_W-1:0]  found_ff;
   logic [BLK_W-1:0]  hblk_ff;

   // pending and output result
   logic              res_status_ff, res_rel_ff;
   logic [REG_W-1:0]  res_region_ff;
   logic [BLK_W-1:0]  res_block_ff;
   logic              out_status_ff, out_rel_ff;
   logic [REG_W-1:0]  out_region_ff;
   logic [BLK_W-1:0]  out_block_ff;

   // link memory
   logic [BLK_W-1:0]  link_mem [MEM_DEPTH];
   logic [BLK_W-1:0]  link_q_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [BLK_W-1:0]  mem_wdata;

   logic [REG_W-1:0]  ci;
   logic [REG_W-1:0]  idle_reg;
   logic              any_idle;
   logic [BLK_W:0]    cnt_inc;
   logic              release_now;
   logic [PTR_W-1:0]  rel_p, rel_n;
   logic [BLK_W-1:0]  implicit_next;
   logic [BLK_W-1:0]  pop_next;

   assign ci = cur_ff[REG_W-1:0];

   always_comb begin
      idle_reg = '0;
      any_idle = 1'b0;
      for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            idle_reg = REG_W'(i);
            any_idle = 1'b1;
         end
      end
   end

   assign sts.is_free      = req_tuser;
   assign sts.cur_end      = cur_ff[REG_W] || steps_ff[STEP_W-1];
   assign sts.cur_hit      = active_ff[ci] && (cnt_ff[ci] != '0) && (head_ff[ci] != '0);
   assign sts.can_activate = any_idle;
   assign sts.free_ok      = mode_ff && active_ff[rr_ff] && (bb_ff != '0)
                             && ({1'b0, bb_ff} <= FILL_W'(REGION_BLOCKS));
   assign sts.need_fill    = {1'b0, bb_ff} >= fill_ff[rr_ff];
   assign sts.fill_last    = fill_ff[rr_ff] == {1'b0, bb_ff};

   assign cnt_inc     = {1'b0, cnt_ff[rr_ff]} + 1'b1;
   assign release_now = cnt_inc >= (BLK_W+1)'(REGION_BLOCKS);
   assign rel_p       = prev_ff[rr_ff];
   assign rel_n       = next_ff[rr_ff];

   assign implicit_next = (hblk_ff == BLK_W'(REGION_BLOCKS)) ? '0 : hblk_ff + 1'b1;
   assign pop_next = ({1'b0, hblk_ff} >= fill_ff[found_ff] || hblk_ff == '0)
                     ? implicit_next : link_q_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {rr_ff, bb_ff};
      mem_wdata = head_ff[rr_ff];
      if (cmd.push) begin
         mem_we = 1'b1;
      end else if (cmd.fill_step) begin
         mem_we    = 1'b1;
         mem_waddr = {rr_ff, fill_ff[rr_ff][BLK_W-1:0]};
         mem_wdata = fill_ff[rr_ff][BLK_W-1:0] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) link_mem[mem_waddr] <= mem_wdata;
      link_q_ff <= link_mem[{found_ff, head_ff[found_ff]}];
   end

   // region table and list
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGIONS; i++) begin
            active_ff[i] <= 1'b0;
            cnt_ff[i]    <= '0;
            head_ff[i]   <= '0;
            next_ff[i]   <= NO_REGION;
            prev_ff[i]   <= NO_REGION;
         end
         list_head_ff <= NO_REGION;
      end else begin
         if (cmd.activate) begin
            active_ff[idle_reg] <= 1'b1;
            cnt_ff[idle_reg]    <= BLK_W'(REGION_BLOCKS);
            head_ff[idle_reg]   <= BLK_W'(1);
            fill_ff[idle_reg]   <= FILL_W'(1);
            prev_ff[idle_reg]   <= NO_REGION;
            next_ff[idle_reg]   <= list_head_ff;
            if (!list_head_ff[REG_W]) prev_ff[list_head_ff[REG_W-1:0]] <= {1'b0, idle_reg};
            list_head_ff <= {1'b0, idle_reg};
         end
         if (cmd.pop) begin
            head_ff[found_ff] <= pop_next;
            cnt_ff[found_ff]  <= cnt_ff[found_ff] - 1'b1;
         end
         if (cmd.fill_step) fill_ff[rr_ff] <= fill_ff[rr_ff] + 1'b1;
         if (cmd.push) begin
            if (release_now) begin
               if (!rel_p[REG_W]) next_ff[rel_p[REG_W-1:0]] <= rel_n;
               if (!rel_n[REG_W]) prev_ff[rel_n[REG_W-1:0]] <= rel_p;
               if (list_head_ff == {1'b0, rr_ff}) list_head_ff <= rel_n;
               active_ff[rr_ff] <= 1'b0;
               cnt_ff[rr_ff]    <= '0;
               head_ff[rr_ff]   <= '0;
               next_ff[rr_ff]   <= NO_REGION;
               prev_ff[rr_ff]   <= NO_REGION;
            end else begin
               head_ff[rr_ff] <= bb_ff;
               cnt_ff[rr_ff]  <= cnt_inc[BLK_W-1:0];
            end
         end
      end
   end

   // request, walk and results
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_tuser;
         rr_ff    <= req_tdata[REG_W-1:0];
         bb_ff    <= req_tdata[REG_W+BLK_W-1:REG_W];
         cur_ff   <= list_head_ff;
         steps_ff <= '0;
      end
      if (cmd.scan_step) begin
         cur_ff   <= next_ff[ci];
         steps_ff <= steps_ff + 1'b1;
      end
      if (cmd.take)     found_ff <= ci;
      if (cmd.activate) found_ff <= idle_reg;
      if (cmd.pop_rd)   hblk_ff  <= head_ff[found_ff];
      if (cmd.set_zero || cmd.set_fail) begin
         res_status_ff <= cmd.set_fail;
         res_region_ff <= '0;
         res_block_ff  <= '0;
         res_rel_ff    <= 1'b0;
      end
      if (cmd.pop) begin
         res_status_ff <= 1'b0;
         res_region_ff <= found_ff;
         res_block_ff  <= hblk_ff;
         res_rel_ff    <= 1'b0;
      end
      if (cmd.push) begin
         res_status_ff <= 1'b0;
         res_region_ff <= '0;
         res_block_ff  <= '0;
         res_rel_ff    <= release_now;
      end
      if (cmd.rsp_load) begin
         out_status_ff <= res_status_ff;
         out_region_ff <= res_region_ff;
         out_block_ff  <= res_block_ff;
         out_rel_ff    <= res_rel_ff;
      end
   end

   assign rsp_tdata = {5'b0, out_block_ff, out_region_ff};
   assign rsp_tuser = {out_rel_ff, out_status_ff};
endmodule
`default_nettype wire

// ===== src/region_block_pool_allocator_core.sv =====
// Top level of the fixed-size block pool allocator over eight regions.
// Depends on rbpa_pkg, rbpa_ctrl and rbpa_dp.
//
//  channel | dir | payload                                   | handshake
//  req     | in  | tdata: region[2:0] block[10:3]; tuser:mode | req_tvalid/req_tready
//  rsp     | out | tdata: region[2:0] block[10:3];            | rsp_tvalid/rsp_tready
//          |     | tuser: status[0] region_released[1]       |
//
// One word at a time; next word taken the cycle after its result is loaded.
// Free: check, then push; if needed, first write links of never-touched blocks up to and
// including the freed one (lazy link fill, one link write a cycle). Ignored free: check only.
// Allocate: walk in list order (at most 8 regions), activate on a miss, pop; failed: walk.
// Output register lets the next word in while a result waits on rsp_tready.
// Synchronous active-high reset; no clearing pass, regions fill lazily.
`default_nettype none
module region_block_pool_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // region[2:0], block_index[10:3], zero above
   input  wire logic        req_tuser,   // mode: 0 allocate, 1 free
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // grant_region[2:0], alloc_block[10:3]
   output logic [1:0]       rsp_tuser    // status[0], region_released[1]
);
   import rbpa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rbpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rbpa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .cmd       (cmd),
      .sts       (sts)
   );
endmodule
`default_nettype wire

// ===== src/rbpa_checker.sv =====
// Port-level checks for the block pool allocator, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module rbpa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 16'd0 && !rsp_tuser[1])
      else $error("failed allocate carries data");

   a_rel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 16'd0)
      else $error("release result carries data");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind region_block_pool_allocator_core rbpa_checker u_rbpa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== tb/sv/rbpa_monitor.sv =====
// Watches both streams of the block pool allocator, predicts every response word
// and compares it field by field. Depends on rbpa_pkg.
`default_nettype none
module rbpa_monitor
   import rbpa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             status;
      logic [REG_W-1:0] region;
      logic [BLK_W-1:0] block;
      logic             released;
   } grant_type;

   // pool state mirror
   logic             act      [NUM_REGIONS];
   int               nfree    [NUM_REGIONS];
   logic [BLK_W-1:0] head_blk [NUM_REGIONS];
   logic [BLK_W-1:0] link     [NUM_REGIONS][256];
   logic [PTR_W-1:0] nxt      [NUM_REGIONS];
   logic [PTR_W-1:0] prv      [NUM_REGIONS];
   logic [PTR_W-1:0] lhead;

   grant_type grant_q[$];

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic pool_clear();
      for (int r = 0; r < NUM_REGIONS; r++) begin
         act[r] = 1'b0;
         nfree[r] = 0;
         head_blk[r] = '0;
         nxt[r] = NO_REGION;
         prv[r] = NO_REGION;
      end
      lhead = NO_REGION;
   endtask

   function automatic grant_type pool_step(input logic is_free, input int r, input int b);
      grant_type g;
      int cur;
      int steps;
      int hit;
      int blk;
      g = '0;
      if (!is_free) begin
         cur = lhead;
         steps = 0;
         hit = NUM_REGIONS;
         while (cur < NUM_REGIONS && steps < NUM_REGIONS) begin
            if (act[cur] && nfree[cur] != 0 && head_blk[cur] != 0) begin
               hit = cur;
               break;
            end
            cur = nxt[cur];
            steps++;
         end
         if (hit == NUM_REGIONS) begin
            for (int k = 0; k < NUM_REGIONS; k++) begin
               if (!act[k]) begin
                  // bring up lowest idle region, ascending free list
                  for (int j = 1; j <= REGION_BLOCKS; j++)
                     link[k][j] = (j < REGION_BLOCKS) ? BLK_W'(j + 1) : '0;
                  head_blk[k] = 1;
                  nfree[k] = REGION_BLOCKS;
                  act[k] = 1'b1;
                  prv[k] = NO_REGION;
                  nxt[k] = lhead;
                  if (lhead < NUM_REGIONS) prv[lhead] = PTR_W'(k);
                  lhead = PTR_W'(k);
                  hit = k;
                  break;
               end
            end
         end
         if (hit == NUM_REGIONS) begin
            g.status = 1'b1;
            return g;
         end
         blk = head_blk[hit];
         head_blk[hit] = (blk >= 1 && blk <= REGION_BLOCKS) ? link[hit][blk] : '0;
         nfree[hit]--;
         g.region = REG_W'(hit);
         g.block = BLK_W'(blk);
         return g;
      end
      // ignored frees: idle region or out-of-range block
      if (r >= NUM_REGIONS || !act[r]) return g;
      if (b == 0 || b > REGION_BLOCKS) return g;
      link[r][b] = head_blk[r];
      head_blk[r] = BLK_W'(b);
      nfree[r]++;
      if (nfree[r] >= REGION_BLOCKS) begin
         // unlink; if it was the list head, head moves on to the next region
         if (prv[r] < NUM_REGIONS) nxt[prv[r]] = nxt[r];
         if (nxt[r] < NUM_REGIONS) prv[nxt[r]] = prv[r];
         if (lhead == r) lhead = nxt[r];
         act[r] = 1'b0;
         nfree[r] = 0;
         head_blk[r] = '0;
         nxt[r] = NO_REGION;
         prv[r] = NO_REGION;
         g.released = 1'b1;
      end
      return g;
   endfunction

   initial begin
      fail_count = 0;
      pending_count = 0;
      pool_clear();
   end

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         pool_clear();
         grant_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            grant_q.push_back(pool_step(req_tuser, req_tdata[2:0], req_tdata[10:3]));
         if (rsp_tvalid && rsp_tready) begin
            if (grant_q.size() == 0) begin
               report("unexpected word", rsp_tdata, 0);
            end else begin
               want = grant_q.pop_front();
               if (rsp_tuser[0] !== want.status) report("status", rsp_tuser[0], want.status);
               if (rsp_tdata[2:0] !== want.region)
                  report("grant_region", rsp_tdata[2:0], want.region);
               if (rsp_tdata[10:3] !== want.block)
                  report("alloc_block", rsp_tdata[10:3], want.block);
               if (rsp_tuser[1] !== want.released)
                  report("region_released", rsp_tuser[1], want.released);
               if (rsp_tdata[15:11] !== '0) report("tdata pad", rsp_tdata[15:11], 0);
            end
         end
      end
      pending_count = grant_q.size();
   end
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Stimulus and verdict for region_block_pool_allocator_core.
// Depends on rbpa_pkg, the core and rbpa_monitor.
`default_nettype none
module tb_top;
   import rbpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD   = 400;     // receiver hold-off, fills output reg and stalls req
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;          // region[2:0], block_index[10:3]
   logic        req_tuser = 1'b0;        // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;               // grant_region[2:0], alloc_block[10:3]
   logic [1:0]  rsp_tuser;               // status[0], region_released[1]

   int fail_count;
   int pending_count;
   int cycles = 0;
   int words_in = 0;                     // accepted request words
   int words_out = 0;                    // accepted response words
   int hold_asked = 0;                   // bumped by stimulus, served by receiver
   int hold_served = 0;
   logic [10:0] owned_q[$];              // blocks granted and not yet handed back

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   region_block_pool_allocator_core dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   rbpa_monitor mon (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .pending_count
   );

   // handshake bookkeeping; granted blocks feed the free stimulus
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** region_block_pool_allocator_core: FAILED **");
         $finish;
      end
      if (!reset) begin
         if (req_tvalid && req_tready) words_in++;
         if (rsp_tvalid && rsp_tready) begin
            words_out++;
            if (rsp_tdata[10:3] != 0) owned_q.push_back(rsp_tdata[10:0]);
         end
      end
   end

   // receiver: runs of always-ready, runs of random stalls, long hold on demand
   initial begin
      int run;
      int mode_sel;
      @(posedge clock);
      forever begin
         if (hold_asked != hold_served) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_served++;
         end
         run = $urandom_range(1, 40);
         mode_sel = $urandom_range(0, 2);
         repeat (run) begin
            case (mode_sel)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // one request word; valid stays up across back-to-back words
   task automatic send(input logic mode, input int r, input int b);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {5'b0, 8'(b), 3'(r)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic idle(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      idle(1);
      while (words_out != words_in) @(posedge clock);
   endtask

   // hand back a granted block; keep it now and then for a double free
   task automatic give_back(input bit keep);
      int k;
      logic [10:0] w;
      k = $urandom_range(0, owned_q.size() - 1);
      w = owned_q[k];
      if (!keep) owned_q.delete(k);
      send(MODE_FREE, w[2:0], w[10:3]);
   endtask

   task automatic random_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 52 || (pick < 90 && owned_q.size() == 0))
         send(MODE_ALLOC, $urandom_range(0, 7), $urandom_range(0, 255));
      else if (pick < 90)
         give_back($urandom_range(0, 15) == 0);
      else
         send(MODE_FREE, $urandom_range(0, 7), $urandom_range(0, 255));   // noise
   endtask

   initial begin
      int burst;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: region 0 comes up, odd frees, early release, reactivation
      send(MODE_ALLOC, 7, 255);            // fields ignored on allocate
      send(MODE_ALLOC, 0, 0);
      send(MODE_ALLOC, 5, 17);
      send(MODE_FREE, 0, 0);               // bad block index
      send(MODE_FREE, 5, 10);              // idle region
      send(MODE_FREE, 7, 255);             // idle top region, top block
      send(MODE_FREE, 0, 3);
      send(MODE_FREE, 0, 3);               // double free, counted again
      send(MODE_FREE, 0, 255);             // never-touched block, releases region
      send(MODE_FREE, 0, 1);               // region now idle: ignored
      send(MODE_ALLOC, 0, 0);              // region 0 back with a fresh list
      send(MODE_ALLOC, 0, 0);
      send(MODE_FREE, 0, 200);
      send(MODE_ALLOC, 0, 0);              // LIFO: gets 200 back
      drain();
      owned_q.delete();
      owned_q.push_back({8'd2, 3'd0});
      owned_q.push_back({8'd200, 3'd0});

      // random mix in bursts
      for (int n = 0; n < 950; ) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            random_word();
            n++;
            if (n == 300) hold_asked++;    // block fills while receiver holds off
            if (n == 620) drain();
         end
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
      end
      drain();

      // a free may first fill never-touched links; let it settle
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("** region_block_pool_allocator_core: PASSED **");
      else
         $display("** region_block_pool_allocator_core: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
